### rtl/ir_range_average_classifier_macros.svh
// Assertion macros used by the checker file of the block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef IR_RANGE_AVERAGE_CLASSIFIER_MACROS_SVH
`define IR_RANGE_AVERAGE_CLASSIFIER_MACROS_SVH

// The property must hold in the same cycle as its condition.
`define IRA_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("ira assertion failed");

// The property must hold in the cycle after its condition.
`define IRA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("ira assertion failed");

`endif

### rtl/ira_pkg.sv
`default_nettype none

package ira_pkg;

  localparam int SAMPLE_W    = 10;
  localparam int MAX_SAMPLES = 16;
  localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int BLK_W       = 5;
  localparam int TICK_W      = 16;
  localparam int COEF_W      = 24;
  localparam int DIST_W      = 24;
  localparam int TGT_W       = 16;
  localparam int PROD_W      = COEF_W + SAMPLE_W;
  localparam int NUM_W       = PROD_W;
  localparam int DVD_W       = PROD_W + 1;
  localparam int ITER_W      = $clog2(NUM_W + 1);
  localparam int SAT_IN_W    = NUM_W + 2;
  localparam int CLS_W       = 2;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [NUM_W-1:0]    RECIP_ONE = NUM_W'(64'd1 << 32);
  localparam logic [SAT_IN_W-1:0] BIAS_Q8   = SAT_IN_W'(108);

  localparam logic [TICK_W-1:0] DECIM_RST     = TICK_W'(1);
  localparam logic [BLK_W-1:0]  SPB_RST       = BLK_W'(16);
  localparam logic [SAMPLE_W-1:0] LOWER_RST   = '0;
  localparam logic [COEF_W-1:0] SLOPE_RST     = COEF_W'(31252);
  localparam logic [COEF_W-1:0] INTERCEPT_RST = COEF_W'(352322);
  localparam logic [TGT_W-1:0]  TARGET_RST    = '0;
  localparam logic [TGT_W-1:0]  OFFSET_RST    = '0;

  typedef enum logic [CLS_W-1:0] {
    CLS_ERROR    = 2'd0,
    CLS_CLOSE    = 2'd1,
    CLS_PARALLEL = 2'd2,
    CLS_FAR      = 2'd3
  } pos_class_e;

  typedef enum logic [2:0] {
    REG_DECIM     = 3'd0,
    REG_SPB       = 3'd1,
    REG_LOWER     = 3'd2,
    REG_SLOPE     = 3'd3,
    REG_INTERCEPT = 3'd4,
    REG_TARGET    = 3'd5,
    REG_OFFSET    = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_AVG_WAIT,
    S_MUL,
    S_SUB,
    S_CHK,
    S_DIV_WAIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [TICK_W-1:0]   decimation_ratio;
    logic [BLK_W-1:0]    samples_per_block;
    logic [SAMPLE_W-1:0] lower_limit;
    logic [COEF_W-1:0]   slope_coeff;
    logic [COEF_W-1:0]   intercept_coeff;
    logic [TGT_W-1:0]    target_distance;
    logic [TGT_W-1:0]    distance_offset;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  den;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [BLK_W-1:0] block_len(input logic [BLK_W-1:0] spb);
    logic [BLK_W-1:0] n;
    n = spb;
    if (n == '0) begin
      n = BLK_W'(1);
    end
    if (int'(n) > MAX_SAMPLES) begin
      n = BLK_W'(MAX_SAMPLES);
    end
    return n;
  endfunction

  function automatic logic signed [DIST_W-1:0] sat_dist(input logic signed [SAT_IN_W-1:0] v);
    logic signed [DIST_W-1:0] r;
    r = v[DIST_W-1:0];
    if (!v[SAT_IN_W-1] && (|v[SAT_IN_W-2:DIST_W-1])) begin
      r = {1'b0, {(DIST_W-1){1'b1}}};
    end else if (v[SAT_IN_W-1] && !(&v[SAT_IN_W-2:DIST_W-1])) begin
      r = {1'b1, {(DIST_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/ir_range_average_classifier.sv
// Side range sensor front end. Each accepted item is one timer tick with a
// 10-bit converter reading; every decimation_ratio-th reading is summed, and
// when samples_per_block readings are in, one result comes out with the block
// average, the in-range flag, the inverse-distance value in Q8 centimeters,
// its change and the too-close, parallel, too-far or error class. An item that
// does not end a block leaves in_ready_o high. An item that ends a block holds
// in_ready_o low while one shared restoring divider first forms the average
// (one quotient bit per cycle) and then the reciprocal, which is skipped when
// the block is out of range or its denominator is not positive, and while a
// still untaken earlier result waits at the output register. Configuration
// registers sit on the APB port at byte addresses 0 to 24 and are to be
// written only while no block is in flight, by the user; the block itself
// does not enforce this.
`default_nettype none

module ir_range_average_classifier import ira_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SAMPLE_W-1:0]      average_raw_o,
  output logic                     in_range_o,
  output logic signed [DIST_W-1:0] distance_o,
  output logic signed [DIST_W-1:0] distance_change_o,
  output logic [CLS_W-1:0]         position_class_o,
  output logic                     class_changed_o
);

  cfg_t     cfg;
  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  ira_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ira_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  ira_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_raw_o     (average_raw_o),
    .in_range_o        (in_range_o),
    .distance_o        (distance_o),
    .distance_change_o (distance_change_o),
    .position_class_o  (position_class_o),
    .class_changed_o   (class_changed_o),
    .div_cmd_o         (div_cmd),
    .div_rsp_i         (div_rsp)
  );

endmodule

`default_nettype wire

### rtl/ira_regs.sv
`default_nettype none

module ira_regs import ira_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t             cfg_q;
  logic             wr_en;
  logic [2:0]       idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decimation_ratio  <= DECIM_RST;
      cfg_q.samples_per_block <= SPB_RST;
      cfg_q.lower_limit       <= LOWER_RST;
      cfg_q.slope_coeff       <= SLOPE_RST;
      cfg_q.intercept_coeff   <= INTERCEPT_RST;
      cfg_q.target_distance   <= TARGET_RST;
      cfg_q.distance_offset   <= OFFSET_RST;
    end else if (wr_en) begin
      case (reg_idx_e'(idx))
        REG_DECIM:     cfg_q.decimation_ratio  <= pwdata[TICK_W-1:0];
        REG_SPB:       cfg_q.samples_per_block <= pwdata[BLK_W-1:0];
        REG_LOWER:     cfg_q.lower_limit       <= pwdata[SAMPLE_W-1:0];
        REG_SLOPE:     cfg_q.slope_coeff       <= pwdata[COEF_W-1:0];
        REG_INTERCEPT: cfg_q.intercept_coeff   <= pwdata[COEF_W-1:0];
        REG_TARGET:    cfg_q.target_distance   <= pwdata[TGT_W-1:0];
        REG_OFFSET:    cfg_q.distance_offset   <= pwdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(idx))
      REG_DECIM:     prdata = PDATA_W'(cfg_q.decimation_ratio);
      REG_SPB:       prdata = PDATA_W'(cfg_q.samples_per_block);
      REG_LOWER:     prdata = PDATA_W'(cfg_q.lower_limit);
      REG_SLOPE:     prdata = PDATA_W'(cfg_q.slope_coeff);
      REG_INTERCEPT: prdata = PDATA_W'(cfg_q.intercept_coeff);
      REG_TARGET:    prdata = PDATA_W'(cfg_q.target_distance);
      REG_OFFSET:    prdata = PDATA_W'(cfg_q.distance_offset);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ira_divider.sv
`default_nettype none

module ira_divider import ira_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  den_q;
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  quot_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [NUM_W:0]    shifted;
  logic [NUM_W:0]    diff;
  logic              ge;
  logic [NUM_W-1:0]  rem_d;

  // One restoring step per cycle: shift in the next numerator bit and subtract.
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cmd_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      num_q  <= cmd_i.num;
      den_q  <= cmd_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

### rtl/ira_core.sv
`default_nettype none

module ira_core import ira_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SAMPLE_W-1:0]      average_raw_o,
  output logic                     in_range_o,
  output logic signed [DIST_W-1:0] distance_o,
  output logic signed [DIST_W-1:0] distance_change_o,
  output logic [CLS_W-1:0]         position_class_o,
  output logic                     class_changed_o,
  output div_cmd_t                 div_cmd_o,
  input  div_rsp_t                 div_rsp_i
);

  state_e                    state_q, state_d;
  logic [TICK_W-1:0]         tick_q;
  logic [BLK_W-1:0]          cnt_q;
  logic [SUM_W-1:0]          sum_q;
  logic [SAMPLE_W-1:0]       avg_q;
  logic                      inr_q;
  logic [PROD_W-1:0]         prod_q;
  logic signed [DVD_W-1:0]   dvd_q;
  logic signed [DIST_W-1:0]  dist_q;
  logic                      err_q;
  logic signed [DIST_W-1:0]  held_dist_q;
  pos_class_e                held_cls_q;
  logic                      out_valid_q;
  logic [SAMPLE_W-1:0]       avg_out_q;
  logic                      inr_out_q;
  logic signed [DIST_W-1:0]  dist_out_q;
  logic signed [DIST_W-1:0]  chg_out_q;
  pos_class_e                cls_out_q;
  logic                      cls_chg_out_q;

  logic                      accept;
  logic [TICK_W-1:0]         tick_next;
  logic                      take;
  logic [BLK_W-1:0]          cnt_inc;
  logic [BLK_W-1:0]          blk_len;
  logic                      end_blk;
  logic                      go_div;
  logic                      load_out;
  logic signed [SAT_IN_W-1:0] dist_raw;
  logic signed [SAT_IN_W-1:0] chg_raw;
  logic signed [SAT_IN_W-1:0] cmp_val;
  logic signed [SAT_IN_W-1:0] tgt_val;
  pos_class_e                cls_new;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tick_next  = tick_q + TICK_W'(1);
  assign take       = accept && (tick_next == cfg_i.decimation_ratio);
  assign cnt_inc    = cnt_q + BLK_W'(1);
  assign blk_len    = block_len(cfg_i.samples_per_block);
  assign end_blk    = take && (cnt_inc >= blk_len);
  assign go_div     = inr_q && !dvd_q[DVD_W-1] && (dvd_q != '0);
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    dist_raw = $signed({{(SAT_IN_W-NUM_W){1'b0}}, div_rsp_i.quot}) - $signed(BIAS_Q8);
    chg_raw  = $signed({{(SAT_IN_W-DIST_W){dist_q[DIST_W-1]}}, dist_q})
             - $signed({{(SAT_IN_W-DIST_W){held_dist_q[DIST_W-1]}}, held_dist_q});
    cmp_val  = $signed({{(SAT_IN_W-DIST_W){dist_q[DIST_W-1]}}, dist_q})
             - $signed({{(SAT_IN_W-TGT_W){1'b0}}, cfg_i.distance_offset});
    tgt_val  = $signed({{(SAT_IN_W-TGT_W){1'b0}}, cfg_i.target_distance});
    if (err_q) begin
      cls_new = CLS_ERROR;
    end else if (cmp_val < tgt_val) begin
      cls_new = CLS_CLOSE;
    end else if (cmp_val > tgt_val) begin
      cls_new = CLS_FAR;
    end else begin
      cls_new = CLS_PARALLEL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (end_blk) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        div_cmd_o.start = 1'b1;
        div_cmd_o.num   = {sum_q, {(NUM_W-SUM_W){1'b0}}};
        div_cmd_o.den   = NUM_W'(blk_len);
        div_cmd_o.iters = ITER_W'(SUM_W);
        state_d         = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUB;
      end
      S_SUB: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (go_div) begin
          div_cmd_o.start = 1'b1;
          div_cmd_o.num   = RECIP_ONE + {1'b0, dvd_q[NUM_W-1:1]};
          div_cmd_o.den   = dvd_q[NUM_W-1:0];
          div_cmd_o.iters = ITER_W'(NUM_W);
          state_d         = S_DIV_WAIT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      held_dist_q <= '0;
      held_cls_q  <= CLS_ERROR;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tick_q <= take ? '0 : tick_next;
      end
      if (take) begin
        sum_q <= sum_q + SUM_W'(sample_i);
        cnt_q <= cnt_inc;
      end
      if ((state_q == S_AVG_WAIT) && div_rsp_i.done) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      if (load_out) begin
        held_cls_q <= cls_new;
        if (!err_q) begin
          held_dist_q <= dist_q;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_AVG_WAIT) && div_rsp_i.done) begin
      avg_q <= div_rsp_i.quot[SAMPLE_W-1:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= {{SAMPLE_W{1'b0}}, cfg_i.slope_coeff} * {{COEF_W{1'b0}}, avg_q};
      inr_q  <= (avg_q >= cfg_i.lower_limit);
    end
    if (state_q == S_SUB) begin
      dvd_q <= $signed({1'b0, prod_q})
             - $signed({{(DVD_W-COEF_W){1'b0}}, cfg_i.intercept_coeff});
    end
    if (state_q == S_CHK) begin
      err_q <= !go_div;
    end
    if ((state_q == S_DIV_WAIT) && div_rsp_i.done) begin
      dist_q <= sat_dist(dist_raw);
    end
    if (load_out) begin
      avg_out_q     <= avg_q;
      inr_out_q     <= inr_q;
      dist_out_q    <= err_q ? held_dist_q : dist_q;
      chg_out_q     <= err_q ? '0 : sat_dist(chg_raw);
      cls_out_q     <= cls_new;
      cls_chg_out_q <= (cls_new != held_cls_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_raw_o     = avg_out_q;
  assign in_range_o        = inr_out_q;
  assign distance_o        = dist_out_q;
  assign distance_change_o = chg_out_q;
  assign position_class_o  = cls_out_q;
  assign class_changed_o   = cls_chg_out_q;

endmodule

`default_nettype wire

### rtl/ira_chk.sv
`default_nettype none

`include "ir_range_average_classifier_macros.svh"

module ira_chk import ira_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [SAMPLE_W-1:0]      average_raw_o,
  input logic                     in_range_o,
  input logic signed [DIST_W-1:0] distance_o,
  input logic signed [DIST_W-1:0] distance_change_o,
  input logic [CLS_W-1:0]         position_class_o,
  input logic                     class_changed_o
);

  logic [SAMPLE_W+2*DIST_W+CLS_W+1:0] payload;

  assign payload = {average_raw_o, in_range_o, distance_o, distance_change_o,
                    position_class_o, class_changed_o};

  `IRA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(payload))
  `IRA_ASSERT_NOW(a_err_no_change, out_valid_o && (position_class_o == CLS_ERROR), distance_change_o == '0)
  `IRA_ASSERT_NOW(a_out_of_range_err, out_valid_o && !in_range_o, position_class_o == CLS_ERROR)
  `IRA_ASSERT_NOW(a_busy_after_item, $fell(in_ready_o), $past(in_valid_i) && $past(in_ready_o))

endmodule

bind ir_range_average_classifier ira_chk u_chk (.*);

`default_nettype wire

### tb/ir_range_average_classifier_check.sv
module ir_range_average_classifier_check import ira_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel_i,
  input  logic                     penable_i,
  input  logic                     pwrite_i,
  input  logic                     pready_i,
  input  logic [PADDR_W-1:0]       paddr_i,
  input  logic [PDATA_W-1:0]       pwdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [SAMPLE_W-1:0]      sample_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [SAMPLE_W-1:0]      average_raw_i,
  input  logic                     in_range_i,
  input  logic signed [DIST_W-1:0] distance_i,
  input  logic signed [DIST_W-1:0] distance_change_i,
  input  logic [CLS_W-1:0]         position_class_i,
  input  logic                     class_changed_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam longint DIST_HI = (longint'(1) <<< (DIST_W - 1)) - 1;
  localparam longint DIST_LO = -(longint'(1) <<< (DIST_W - 1));
  localparam longint RANGE_BIAS = 108;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      average_raw;
    logic                     in_range;
    logic signed [DIST_W-1:0] distance;
    logic signed [DIST_W-1:0] distance_change;
    pos_class_e               position_class;
    logic                     class_changed;
  } block_result_t;

  cfg_t              cfg;
  logic [TICK_W-1:0] tick_cnt;
  logic [BLK_W-1:0]  readings;
  logic [SUM_W-1:0]  reading_sum;
  longint            held_distance;
  pos_class_e        held_class;
  block_result_t     expected_blocks[$];
  block_result_t     want;
  int                failures;

  function automatic longint clamp_dist(input longint v);
    if (v > DIST_HI) begin
      return DIST_HI;
    end
    if (v < DIST_LO) begin
      return DIST_LO;
    end
    return v;
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void take_tick(input logic [SAMPLE_W-1:0] value);
    logic [TICK_W-1:0]   next_tick;
    int unsigned         span;
    logic [SAMPLE_W-1:0] avg;
    longint              den;
    longint              new_dist;
    longint              change;
    longint              rel;
    longint unsigned     uden;
    longint unsigned     quo;
    pos_class_e          cls;
    block_result_t       res;
    next_tick = tick_cnt + 1'b1;
    if (next_tick != cfg.decimation_ratio) begin
      tick_cnt = next_tick;
      return;
    end
    tick_cnt = '0;
    reading_sum = reading_sum + value;
    readings = readings + 1'b1;
    span = (cfg.samples_per_block == '0) ? 1 : cfg.samples_per_block;
    if (span > MAX_SAMPLES) begin
      span = MAX_SAMPLES;
    end
    if (readings < span) begin
      return;
    end
    avg = SAMPLE_W'(reading_sum / span);
    reading_sum = '0;
    readings = '0;
    res.average_raw = avg;
    res.in_range = (avg >= cfg.lower_limit);
    den = longint'(cfg.slope_coeff) * longint'(avg) - longint'(cfg.intercept_coeff);
    new_dist = held_distance;
    change = 0;
    cls = CLS_ERROR;
    if (res.in_range && den > 0) begin
      uden = den;
      quo = ((64'd1 << 32) + (uden >> 1)) / uden;
      new_dist = clamp_dist(longint'(quo) - RANGE_BIAS);
      change = clamp_dist(new_dist - held_distance);
      rel = new_dist - longint'(cfg.distance_offset);
      if (rel < longint'(cfg.target_distance)) begin
        cls = CLS_CLOSE;
      end else if (rel > longint'(cfg.target_distance)) begin
        cls = CLS_FAR;
      end else begin
        cls = CLS_PARALLEL;
      end
      held_distance = new_dist;
    end
    res.distance = DIST_W'(new_dist);
    res.distance_change = DIST_W'(change);
    res.position_class = cls;
    res.class_changed = (cls != held_class);
    held_class = cls;
    expected_blocks.push_back(res);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{decimation_ratio: DECIM_RST, samples_per_block: SPB_RST,
              lower_limit: LOWER_RST, slope_coeff: SLOPE_RST,
              intercept_coeff: INTERCEPT_RST, target_distance: TARGET_RST,
              distance_offset: OFFSET_RST};
      tick_cnt = '0;
      readings = '0;
      reading_sum = '0;
      held_distance = 0;
      held_class = CLS_ERROR;
      expected_blocks.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:2]))
          REG_DECIM:     cfg.decimation_ratio = pwdata_i[TICK_W-1:0];
          REG_SPB:       cfg.samples_per_block = pwdata_i[BLK_W-1:0];
          REG_LOWER:     cfg.lower_limit = pwdata_i[SAMPLE_W-1:0];
          REG_SLOPE:     cfg.slope_coeff = pwdata_i[COEF_W-1:0];
          REG_INTERCEPT: cfg.intercept_coeff = pwdata_i[COEF_W-1:0];
          REG_TARGET:    cfg.target_distance = pwdata_i[TGT_W-1:0];
          REG_OFFSET:    cfg.distance_offset = pwdata_i[TGT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          note_failure($sformatf("unexpected result: average %0d distance %0d class %0d",
                                 average_raw_i, distance_i, position_class_i));
        end else begin
          want = expected_blocks.pop_front();
          if (average_raw_i !== want.average_raw || in_range_i !== want.in_range ||
              distance_i !== want.distance || distance_change_i !== want.distance_change ||
              position_class_i !== want.position_class ||
              class_changed_i !== want.class_changed) begin
            note_failure($sformatf({"result mismatch (expected/actual): average %0d/%0d ",
                                    "in_range %0b/%0b distance %0d/%0d change %0d/%0d ",
                                    "class %0d/%0d class_changed %0b/%0b"},
                                   want.average_raw, average_raw_i,
                                   want.in_range, in_range_i,
                                   want.distance, distance_i,
                                   want.distance_change, distance_change_i,
                                   want.position_class, position_class_i,
                                   want.class_changed, class_changed_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        take_tick(sample_i);
      end
      fail_count_o <= failures;
      pending_o <= expected_blocks.size();
    end
  end

endmodule

### tb/ir_range_average_classifier_test.sv
module ir_range_average_classifier_test;
  import ira_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_TICKS = 900;
  localparam int CALM_TAIL    = 150;
  localparam int unsigned COEF_MAX = (1 << COEF_W) - 1;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [SAMPLE_W-1:0]      sample_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0]      average_raw_o;
  logic                     in_range_o;
  logic signed [DIST_W-1:0] distance_o;
  logic signed [DIST_W-1:0] distance_change_o;
  logic [CLS_W-1:0]         position_class_o;
  logic                     class_changed_o;

  logic        idle_en = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int          failures;
  int          blocks_in_flight;
  int unsigned sent;
  int unsigned burst;
  int unsigned ratio;

  always #5 clk_i = ~clk_i;

  ir_range_average_classifier u_dut (.*);

  ir_range_average_classifier_check u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .pready_i          (pready),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_raw_i     (average_raw_o),
    .in_range_i        (in_range_o),
    .distance_i        (distance_o),
    .distance_change_i (distance_change_o),
    .position_class_i  (position_class_o),
    .class_changed_i   (class_changed_o),
    .fail_count_o      (failures),
    .pending_o         (blocks_in_flight)
  );

  always @(posedge clk_i) begin
    if (!idle_en) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input int unsigned value, input int width);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= (PDATA_W'($urandom) << width) | PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [SAMPLE_W-1:0] value);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (blocks_in_flight != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_coeff(input int unsigned dflt);
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return 0;
      2: return $urandom & COEF_MAX;
      3: return $urandom_range(1, 70000);
      4: return $urandom_range(dflt / 2, dflt * 2);
      default: return dflt;
    endcase
  endfunction

  function automatic int unsigned pick_q8();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return (1 << TGT_W) - 1;
      default: return $urandom_range(0, (1 << TGT_W) - 1);
    endcase
  endfunction

  function automatic int unsigned pick_lower();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return (1 << SAMPLE_W) - 1;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default coefficients: negative denominator, then small and large readings.
    write_reg(REG_SPB, 1, BLK_W);
    send_tick(0);
    send_tick(11);
    send_tick(12);
    send_tick(1023);
    wait_drained(DRAIN_CYCLES);

    // A denominator of exactly 2^16 lands on the target; zero denominator is an error.
    write_reg(REG_SLOPE, 65536, COEF_W);
    write_reg(REG_INTERCEPT, 0, COEF_W);
    write_reg(REG_TARGET, 65428, TGT_W);
    send_tick(1);
    send_tick(2);
    send_tick(0);
    wait_drained(DRAIN_CYCLES);

    // Below the lower limit, then just at it.
    write_reg(REG_SLOPE, 1, COEF_W);
    write_reg(REG_LOWER, 1023, SAMPLE_W);
    write_reg(REG_TARGET, 65535, TGT_W);
    write_reg(REG_OFFSET, 65535, TGT_W);
    send_tick(1022);
    send_tick(1023);
    wait_drained(DRAIN_CYCLES);

    // Extreme coefficients drive the distance and its change into saturation.
    write_reg(REG_LOWER, 0, SAMPLE_W);
    write_reg(REG_SLOPE, COEF_MAX, COEF_W);
    write_reg(REG_INTERCEPT, COEF_MAX, COEF_W);
    write_reg(REG_TARGET, 0, TGT_W);
    write_reg(REG_OFFSET, 0, TGT_W);
    send_tick(1);
    send_tick(1023);
    wait_drained(DRAIN_CYCLES);
    write_reg(REG_SLOPE, 1, COEF_W);
    write_reg(REG_INTERCEPT, 0, COEF_W);
    send_tick(1);
    wait_drained(DRAIN_CYCLES);
    write_reg(REG_SLOPE, COEF_MAX, COEF_W);
    send_tick(1023);
    wait_drained(DRAIN_CYCLES);

    // Oversized block length, then a zero length set in the middle of the block.
    write_reg(REG_SLOPE, SLOPE_RST, COEF_W);
    write_reg(REG_INTERCEPT, INTERCEPT_RST, COEF_W);
    write_reg(REG_SPB, 31, BLK_W);
    repeat (5) send_tick(1023);
    wait_drained(DRAIN_CYCLES);
    write_reg(REG_SPB, 0, BLK_W);
    send_tick(1023);
    wait_drained(DRAIN_CYCLES);

    // A long ratio leaves the tick count part way through a period, and a
    // shorter ratio then closes that period with the next tick.
    write_reg(REG_DECIM, 65535, TICK_W);
    repeat (3) send_tick(pick_sample());
    wait_drained(DRAIN_CYCLES);
    write_reg(REG_DECIM, 4, TICK_W);
    send_tick(pick_sample());
    wait_drained(DRAIN_CYCLES);

    // Each phase sends a whole number of ratio periods, so the tick count
    // is back at zero before the ratio changes.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      idle_en <= (sent + CALM_TAIL < RANDOM_TICKS) && ($urandom_range(0, 3) != 0);
      ratio = $urandom_range(1, 4);
      write_reg(REG_DECIM, ratio, TICK_W);
      write_reg(REG_SPB, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 4), BLK_W);
      write_reg(REG_LOWER, pick_lower(), SAMPLE_W);
      write_reg(REG_SLOPE, pick_coeff(SLOPE_RST), COEF_W);
      write_reg(REG_INTERCEPT, pick_coeff(INTERCEPT_RST), COEF_W);
      write_reg(REG_TARGET, pick_q8(), TGT_W);
      write_reg(REG_OFFSET, pick_q8(), TGT_W);
      burst = ratio * $urandom_range(8, 24);
      repeat (burst) begin
        send_tick(pick_sample());
        if ($urandom_range(0, 63) == 0) begin
          wait_drained(0);
        end
      end
      sent += burst;
      wait_drained(DRAIN_CYCLES);
    end

    if (failures == 0 && blocks_in_flight == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
